### hw/rtl/rsh_pkg.sv
// Shared types, constants and the per-channel sharpen function of the RGB cross sharpener.
// Used by every other file of the block except rsh_ram; depends on nothing.
`default_nettype none

package rsh_pkg;

    // Field and register widths.
    localparam int CH_BITS         = 8;
    localparam int PIX_BITS        = 3 * CH_BITS;
    localparam int LINE_WORD_BITS  = 2 * PIX_BITS;
    localparam int ROW_BITS        = 16;
    localparam int COL_BITS        = 10;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CMP_BITS        = 17;

    // Sizes and reset values.
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MIN_SIZE          = 3;
    localparam int CENTER_GAIN       = 5;
    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(1024);
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(768);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Offset of an emitted position relative to the interior pixel.
    typedef enum logic [1:0] {
        POS_LOW  = 2'd0,
        POS_MID  = 2'd1,
        POS_HIGH = 2'd2
    } pos_t;

    // Which frame borders the interior pixel also covers.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    // One computed interior pixel handed to the result sequencer.
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [PIX_BITS-1:0] pix;
        border_t             border;
    } job_t;

    // Five times the center minus the four neighbors, clamped to the channel range.
    function automatic logic [CH_BITS-1:0] sharpen_channel(
        input logic [CH_BITS-1:0] ctr,
        input logic [CH_BITS-1:0] up,
        input logic [CH_BITS-1:0] dn,
        input logic [CH_BITS-1:0] lf,
        input logic [CH_BITS-1:0] rt
    );
        logic signed [CH_BITS+3:0] v;
        v = (CH_BITS+4)'(ctr) * (CH_BITS+4)'(CENTER_GAIN) - (CH_BITS+4)'(up)
            - (CH_BITS+4)'(dn) - (CH_BITS+4)'(lf) - (CH_BITS+4)'(rt);
        if (v < 0)
            return '0;
        else if (v > $signed((CH_BITS+4)'({CH_BITS{1'b1}})))
            return '1;
        else
            return v[CH_BITS-1:0];
    endfunction

    // Sharpen all three channels of a packed red, green, blue pixel.
    function automatic logic [PIX_BITS-1:0] sharpen_pixel(
        input logic [PIX_BITS-1:0] ctr,
        input logic [PIX_BITS-1:0] up,
        input logic [PIX_BITS-1:0] dn,
        input logic [PIX_BITS-1:0] lf,
        input logic [PIX_BITS-1:0] rt
    );
        logic [PIX_BITS-1:0] res;
        res = '0;
        for (int k = 0; k < 3; k++)
        begin
            res[k*CH_BITS +: CH_BITS] = sharpen_channel(ctr[k*CH_BITS +: CH_BITS],
                up[k*CH_BITS +: CH_BITS], dn[k*CH_BITS +: CH_BITS],
                lf[k*CH_BITS +: CH_BITS], rt[k*CH_BITS +: CH_BITS]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rsh_in_if.sv
// Input pixel channel: valid, ready and one red, green, blue pixel.
// Depends on rsh_pkg for the channel width.
`default_nettype none

interface rsh_in_if;
    logic                          valid;
    logic                          ready;
    logic [rsh_pkg::CH_BITS-1:0]   in_red;
    logic [rsh_pkg::CH_BITS-1:0]   in_green;
    logic [rsh_pkg::CH_BITS-1:0]   in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/rsh_out_if.sv
// Result channel: valid, ready, position, sharpened pixel and last-of-item flag.
// Depends on rsh_pkg for the field widths.
`default_nettype none

interface rsh_out_if;
    logic                          valid;
    logic                          ready;
    logic [rsh_pkg::ROW_BITS-1:0]  out_row;
    logic [rsh_pkg::COL_BITS-1:0]  out_col;
    logic [rsh_pkg::CH_BITS-1:0]   out_red;
    logic [rsh_pkg::CH_BITS-1:0]   out_green;
    logic [rsh_pkg::CH_BITS-1:0]   out_blue;
    logic                          run_last;

    modport source (output valid, output out_row, output out_col, output out_red,
                    output out_green, output out_blue, output run_last, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_red,
                    input out_green, input out_blue, input run_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rsh_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
`default_nettype none

module rsh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read; data holds while the read is not enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/rsh_core.sv
// Raster counters, line buffer memory, cross window and the sharpen stage.
// Depends on rsh_pkg, rsh_in_if and rsh_ram.
`default_nettype none

module rsh_core #(
    parameter int MAX_WIDTH = rsh_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rsh_in_if.sink                             in_ch,
    input  wire logic [rsh_pkg::CMP_BITS-1:0]  width_eff,
    input  wire logic [rsh_pkg::CMP_BITS-1:0]  height_eff,
    output      logic                          job_valid,
    input  wire logic                          job_ready,
    output      rsh_pkg::job_t                 job
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CXW = (CW > rsh_pkg::COL_BITS) ? CW : rsh_pkg::COL_BITS;
    localparam int PB  = rsh_pkg::PIX_BITS;
    localparam int CB  = rsh_pkg::CMP_BITS;

    logic                          in_acc;
    logic [CW-1:0]                 col_reg, col_next;
    logic [rsh_pkg::ROW_BITS-1:0]  row_reg, row_next;

    logic                          s1_valid_reg, s1_valid_next;
    logic [PB-1:0]                 s1_pix_reg;
    logic [CW-1:0]                 s1_col_reg;
    logic [rsh_pkg::ROW_BITS-1:0]  s1_row_reg;
    logic                          s1_prod;
    logic                          s1_go;

    logic [2*PB-1:0]               line_rd;
    logic [PB-1:0]                 above1;
    logic [PB-1:0]                 above2;

    logic [PB-1:0]                 win_up_reg, win_ctr_reg, win_dn_reg, win_lf_reg;

    logic [CW-1:0]                 col_m1;
    logic [CXW-1:0]                col_m1_x;

    // Item handshake: stage one drains when its item needs no result slot or one is free.
    assign in_acc        = in_ch.valid && in_ch.ready;
    assign s1_prod       = (s1_row_reg >= rsh_pkg::ROW_BITS'(2)) && (s1_col_reg >= CW'(2));
    assign s1_go         = s1_valid_reg && (!s1_prod || job_ready);
    assign in_ch.ready   = !s1_valid_reg || s1_go;
    assign s1_valid_next = in_acc || (s1_valid_reg && !s1_go);

    // Raster position of the next pixel.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (CB'(col_reg) + CB'(1) >= width_eff)
            begin
                col_next = '0;
                if (CB'(row_reg) + CB'(1) >= height_eff)
                    row_next = '0;
                else
                    row_next = row_reg + rsh_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage one payload: the accepted pixel and where it sits.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    // Both line buffers share one word per column: two rows above, then one row above.
    // Consecutive pixels never share a column, so the read and the write-back never collide.
    rsh_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (line_rd),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data ({above1, s1_pix_reg})
    );

    assign above2 = line_rd[2*PB-1:PB];
    assign above1 = line_rd[PB-1:0];

    // Cross window: the previous column (three rows) and the center row two columns back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_up_reg  <= '0;
            win_ctr_reg <= '0;
            win_dn_reg  <= '0;
            win_lf_reg  <= '0;
        end
        else if (s1_go)
        begin
            win_lf_reg  <= win_ctr_reg;
            win_up_reg  <= above2;
            win_ctr_reg <= above1;
            win_dn_reg  <= s1_pix_reg;
        end
    end

    // Interior pixel one row up and one column left, with the borders it covers.
    assign col_m1   = s1_col_reg - CW'(1);
    assign col_m1_x = CXW'(col_m1);

    assign job_valid        = s1_valid_reg && s1_prod;
    assign job.row          = s1_row_reg - rsh_pkg::ROW_BITS'(1);
    assign job.col          = col_m1_x[rsh_pkg::COL_BITS-1:0];
    assign job.pix          = rsh_pkg::sharpen_pixel(win_ctr_reg, win_up_reg, win_dn_reg,
                                                     win_lf_reg, above1);
    assign job.border.top    = (s1_row_reg == rsh_pkg::ROW_BITS'(2));
    assign job.border.bottom = (CB'(s1_row_reg) + CB'(1) == height_eff);
    assign job.border.left   = (s1_col_reg == CW'(2));
    assign job.border.right  = (CB'(s1_col_reg) + CB'(1) == width_eff);

endmodule

`default_nettype wire

### hw/rtl/rsh_seq.sv
// Result register and sequencer: emits one interior pixel and its border copies in raster order.
// Depends on rsh_pkg and rsh_out_if.
`default_nettype none

module rsh_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output      logic           job_ready,
    input  wire rsh_pkg::job_t  job,
    rsh_out_if.source           out_ch
);

    localparam int RB = rsh_pkg::ROW_BITS;
    localparam int CB = rsh_pkg::COL_BITS;
    localparam int CH = rsh_pkg::CH_BITS;

    logic                 s2_valid_reg, s2_valid_next;
    rsh_pkg::job_t        job_reg;
    rsh_pkg::pos_t        dr_reg, dr_next;
    rsh_pkg::pos_t        dc_reg, dc_next;
    rsh_pkg::pos_t        first_dc_held;
    logic                 col_last, row_last, last;
    logic                 out_acc, load;
    logic [RB-1:0]        row_pos;
    logic [CB-1:0]        col_pos;

    assign first_dc_held = job_reg.border.left ? rsh_pkg::POS_LOW : rsh_pkg::POS_MID;

    // End of a row of the block and end of the whole block.
    assign col_last = (dc_reg == rsh_pkg::POS_HIGH) ||
                      (dc_reg == rsh_pkg::POS_MID && !job_reg.border.right);
    assign row_last = (dr_reg == rsh_pkg::POS_HIGH) ||
                      (dr_reg == rsh_pkg::POS_MID && !job_reg.border.bottom);
    assign last     = col_last && row_last;

    assign out_acc   = out_ch.valid && out_ch.ready;
    assign job_ready = !s2_valid_reg || (out_ch.ready && last);
    assign load      = job_valid && job_ready;

    // Next position in the block.
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        dr_next       = dr_reg;
        dc_next       = dc_reg;
        if (load)
        begin
            s2_valid_next = 1'b1;
            dr_next       = job.border.top ? rsh_pkg::POS_LOW : rsh_pkg::POS_MID;
            dc_next       = job.border.left ? rsh_pkg::POS_LOW : rsh_pkg::POS_MID;
        end
        else if (out_acc)
        begin
            if (last)
            begin
                s2_valid_next = 1'b0;
            end
            else if (col_last)
            begin
                dc_next = first_dc_held;
                dr_next = (dr_reg == rsh_pkg::POS_LOW) ? rsh_pkg::POS_MID : rsh_pkg::POS_HIGH;
            end
            else
            begin
                dc_next = (dc_reg == rsh_pkg::POS_LOW) ? rsh_pkg::POS_MID : rsh_pkg::POS_HIGH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            dr_reg       <= rsh_pkg::POS_MID;
            dc_reg       <= rsh_pkg::POS_MID;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            dr_reg       <= dr_next;
            dc_reg       <= dc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
    end

    // Position decode: one less, same, or one more than the interior pixel.
    always_comb
    begin
        unique case (dr_reg)
            rsh_pkg::POS_LOW:  row_pos = job_reg.row - RB'(1);
            rsh_pkg::POS_MID:  row_pos = job_reg.row;
            rsh_pkg::POS_HIGH: row_pos = job_reg.row + RB'(1);
            default:           row_pos = job_reg.row;
        endcase
        unique case (dc_reg)
            rsh_pkg::POS_LOW:  col_pos = job_reg.col - CB'(1);
            rsh_pkg::POS_MID:  col_pos = job_reg.col;
            rsh_pkg::POS_HIGH: col_pos = job_reg.col + CB'(1);
            default:           col_pos = job_reg.col;
        endcase
    end

    assign out_ch.valid     = s2_valid_reg;
    assign out_ch.out_row   = row_pos;
    assign out_ch.out_col   = col_pos;
    assign out_ch.out_red   = job_reg.pix[3*CH-1:2*CH];
    assign out_ch.out_green = job_reg.pix[2*CH-1:CH];
    assign out_ch.out_blue  = job_reg.pix[CH-1:0];
    assign out_ch.run_last  = last;

endmodule

`default_nettype wire

### hw/rtl/rgb_sharpen_3x3_cross.sv
// Top level of the RGB 3x3 cross sharpener: configuration registers, core and sequencer.
// Depends on rsh_pkg, rsh_in_if, rsh_out_if, rsh_core and rsh_seq.
//
//   Port       Dir   Handshake          Payload
//   in_ch      in    valid / ready      in_red, in_green, in_blue
//   out_ch     out   valid / ready      out_row, out_col, out_red/green/blue, run_last
//   cfg_*      in    cfg_we only        cfg_index, cfg_data
//
// One pixel is taken per clock while the input is not stalled; a pixel passes the line buffer
// read stage, and its first result is then loaded into the result register.
// A pixel on a frame border holds the input while its border copies (up to eight) are emitted
// by the result sequencer, which emits one position per cycle while the output is ready.
// Reset clears the raster counters, window and pipeline valids; the line buffer memory is not
// cleared and holds its contents until the first row pair of a frame writes it.
// Input stalls only while the sequencer still holds results and the read stage is full.
`default_nettype none

module rgb_sharpen_3x3_cross #(
    parameter int MAX_WIDTH = rsh_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    rsh_in_if.sink                                   in_ch,
    rsh_out_if.source                                out_ch,
    input  wire logic                                cfg_we,
    input  wire logic [rsh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [rsh_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int CB = rsh_pkg::CMP_BITS;

    logic [rsh_pkg::WIDTH_REG_BITS-1:0]  image_width_reg, image_width_next;
    logic [rsh_pkg::HEIGHT_REG_BITS-1:0] image_height_reg, image_height_next;
    logic [CB-1:0]                       width_eff, height_eff;

    logic                                job_valid, job_ready;
    rsh_pkg::job_t                       job;

    // Register write decode.
    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_we)
        begin
            unique case (rsh_pkg::cfg_reg_t'(cfg_index))
                rsh_pkg::REG_IMAGE_WIDTH:
                    image_width_next = cfg_data[rsh_pkg::WIDTH_REG_BITS-1:0];
                rsh_pkg::REG_IMAGE_HEIGHT:
                    image_height_next = cfg_data[rsh_pkg::HEIGHT_REG_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= rsh_pkg::WIDTH_RESET;
            image_height_reg <= rsh_pkg::HEIGHT_RESET;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // Frame size in use: width clamped to the line buffer depth, both at least three.
    always_comb
    begin
        if (CB'(image_width_reg) < CB'(rsh_pkg::MIN_SIZE))
            width_eff = CB'(rsh_pkg::MIN_SIZE);
        else if (CB'(image_width_reg) > CB'(MAX_WIDTH))
            width_eff = CB'(MAX_WIDTH);
        else
            width_eff = CB'(image_width_reg);

        if (CB'(image_height_reg) < CB'(rsh_pkg::MIN_SIZE))
            height_eff = CB'(rsh_pkg::MIN_SIZE);
        else
            height_eff = CB'(image_height_reg);
    end

    rsh_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    rsh_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

### hw/rtl/rsh_checker.sv
// Port-level checks of the RGB cross sharpener, bound to the top level.
// Depends on rsh_pkg for field widths and on rgb_sharpen_3x3_cross for the bind.
`default_nettype none

module rsh_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          run_last,
    input wire logic [rsh_pkg::ROW_BITS-1:0]  out_row,
    input wire logic [rsh_pkg::COL_BITS-1:0]  out_col
);

    // A stalled result keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_row) && $stable(out_col))
        else $error("result position changed while stalled");

    // An item with more results to come keeps the result register full.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside the results of one item");

    // Within one item the next result is on the same row or the row below.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
            (out_row == $past(out_row)) ||
            (out_row == $past(out_row) + rsh_pkg::ROW_BITS'(1)))
        else $error("results of one item out of raster order");

endmodule

bind rgb_sharpen_3x3_cross rsh_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .run_last  (out_ch.run_last),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col)
);

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the RGB 3x3 cross sharpener: drives raster pixels, predicts every
// emitted border and interior position and compares them field by field as they come out.
// Depends on rsh_pkg, rsh_in_if, rsh_out_if and rgb_sharpen_3x3_cross.
`default_nettype none

module testbench;

    localparam int MAX_W        = rsh_pkg::MAX_WIDTH_DEFAULT;
    localparam int SETTLE_TICKS = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 30;

    typedef struct packed {
        logic [rsh_pkg::CH_BITS-1:0] red;
        logic [rsh_pkg::CH_BITS-1:0] green;
        logic [rsh_pkg::CH_BITS-1:0] blue;
    } rgb_t;

    typedef struct {
        logic [rsh_pkg::ROW_BITS-1:0] row;
        logic [rsh_pkg::COL_BITS-1:0] col;
        rgb_t                         px;
        logic                         last;
    } position_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rsh_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [rsh_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    rsh_in_if  pix_in ();
    rsh_out_if pix_out ();

    rgb_sharpen_3x3_cross u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (pix_in),
        .out_ch    (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: line buffers, window, raster position and register copies.
    rgb_t                                line_one [MAX_W];
    rgb_t                                line_two [MAX_W];
    rgb_t                                win [6];
    int                                  row_pos;
    int                                  col_pos;
    logic [rsh_pkg::WIDTH_REG_BITS-1:0]  cfg_width;
    logic [rsh_pkg::HEIGHT_REG_BITS-1:0] cfg_height;

    // Stimulus bookkeeping.
    rgb_t      pending_pixels [$];
    position_t awaited_results [$];
    int        pixels_queued;
    int        pixels_taken;
    int        results_checked;
    int        mismatch_count;
    int        settings_used;
    int        cycle_count;
    int        gen_row;
    int        gen_col;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_left;
    logic      in_taken;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Frame sizes as the block uses them after clamping.
    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w < rsh_pkg::MIN_SIZE)
            w = rsh_pkg::MIN_SIZE;
        if (w > MAX_W)
            w = MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = cfg_height;
        if (h < rsh_pkg::MIN_SIZE)
            h = rsh_pkg::MIN_SIZE;
        return h;
    endfunction

    // Five times the center minus the cross neighbors, clamped to one channel.
    function automatic logic [rsh_pkg::CH_BITS-1:0] cross_level(
        input logic [rsh_pkg::CH_BITS-1:0] c,
        input logic [rsh_pkg::CH_BITS-1:0] u, input logic [rsh_pkg::CH_BITS-1:0] d,
        input logic [rsh_pkg::CH_BITS-1:0] l, input logic [rsh_pkg::CH_BITS-1:0] r);
        int v;
        v = rsh_pkg::CENTER_GAIN * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[rsh_pkg::CH_BITS-1:0];
    endfunction

    // Advance the predicted raster position and queue the positions this pixel completes.
    task automatic predict_sharpen(input rgb_t px);
        int        w;
        int        h;
        int        r;
        int        c;
        rgb_t      a1;
        rgb_t      a2;
        rgb_t      res;
        position_t entry;
        position_t hits [$];
        w  = eff_width();
        h  = eff_height();
        a2 = line_two[col_pos];
        a1 = line_one[col_pos];
        if (row_pos >= 2 && col_pos >= 2)
        begin
            res.red   = cross_level(win[1].red, win[0].red, win[2].red, win[4].red, a1.red);
            res.green = cross_level(win[1].green, win[0].green, win[2].green, win[4].green,
                                    a1.green);
            res.blue  = cross_level(win[1].blue, win[0].blue, win[2].blue, win[4].blue, a1.blue);
            r = row_pos - 1;
            c = col_pos - 1;
            // Raster order over the block around the interior pixel, borders included.
            for (int dr = 0; dr < 3; dr++)
            begin
                if (dr == 0 && r != 1)
                    continue;
                if (dr == 2 && r != h - 2)
                    continue;
                for (int dc = 0; dc < 3; dc++)
                begin
                    if (dc == 0 && c != 1)
                        continue;
                    if (dc == 2 && c != w - 2)
                        continue;
                    entry.row  = rsh_pkg::ROW_BITS'(r + dr - 1);
                    entry.col  = rsh_pkg::COL_BITS'(c + dc - 1);
                    entry.px   = res;
                    entry.last = 1'b0;
                    hits.push_back(entry);
                end
            end
            if (hits.size() > 0)
                hits[hits.size() - 1].last = 1'b1;
            foreach (hits[k])
                awaited_results.push_back(hits[k]);
        end
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = a2;
        win[1] = a1;
        win[2] = px;
        line_two[col_pos] = a1;
        line_one[col_pos] = px;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // Compare one emitted position with the oldest one awaited.
    task automatic check_result();
        position_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result row %0d col %0d",
                                      pix_out.out_row, pix_out.out_col));
            return;
        end
        want = awaited_results.pop_front();
        results_checked++;
        if (pix_out.out_row !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", pix_out.out_row, want.row));
        if (pix_out.out_col !== want.col)
            report_mismatch($sformatf("col %0d, want %0d", pix_out.out_col, want.col));
        if (pix_out.out_red !== want.px.red)
            report_mismatch($sformatf("red %0d, want %0d at %0d,%0d", pix_out.out_red,
                                      want.px.red, want.row, want.col));
        if (pix_out.out_green !== want.px.green)
            report_mismatch($sformatf("green %0d, want %0d at %0d,%0d", pix_out.out_green,
                                      want.px.green, want.row, want.col));
        if (pix_out.out_blue !== want.px.blue)
            report_mismatch($sformatf("blue %0d, want %0d at %0d,%0d", pix_out.out_blue,
                                      want.px.blue, want.row, want.col));
        if (pix_out.run_last !== want.last)
            report_mismatch($sformatf("run_last %0b, want %0b at %0d,%0d", pix_out.run_last,
                                      want.last, want.row, want.col));
    endtask

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        in_taken <= rst_n && pix_in.valid && pix_in.ready;
        if (rst_n)
        begin
            if (pix_in.valid && pix_in.ready)
            begin
                predict_sharpen(rgb_t'{pix_in.in_red, pix_in.in_green, pix_in.in_blue});
                pixels_taken++;
            end
            if (pix_out.valid && pix_out.ready)
                check_result();
        end
    end

    // Pixel driver: offers the next queued item at the falling edge, with random gaps.
    always @(negedge clk)
    begin : drive_pixels
        rgb_t nxt;
        if (rst_n && (!pix_in.valid || in_taken))
        begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_pixels.pop_front();
                pix_in.valid    <= 1'b1;
                pix_in.in_red   <= nxt.red;
                pix_in.in_green <= nxt.green;
                pix_in.in_blue  <= nxt.blue;
            end
            else
                pix_in.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                pix_out.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results still awaited.",
                     cycle_count, awaited_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic rgb_t random_pixel();
        rgb_t p;
        logic [rsh_pkg::CH_BITS-1:0] ch [3];
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(7))
                0:       ch[k] = '0;
                1:       ch[k] = '1;
                default: ch[k] = rsh_pkg::CH_BITS'($urandom_range(255));
            endcase
        end
        p = rgb_t'{ch[0], ch[1], ch[2]};
        return p;
    endfunction

    task automatic write_register(input rsh_pkg::cfg_reg_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= rsh_pkg::CFG_DATA_BITS'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == rsh_pkg::REG_IMAGE_WIDTH)
            cfg_width = rsh_pkg::WIDTH_REG_BITS'(value);
        else
            cfg_height = rsh_pkg::HEIGHT_REG_BITS'(value);
    endtask

    task automatic set_frame(input int w, input int h);
        write_register(rsh_pkg::REG_IMAGE_WIDTH, w);
        write_register(rsh_pkg::REG_IMAGE_HEIGHT, h);
        settings_used++;
    endtask

    // Queue one pixel and track where the raster will stand after it.
    task automatic queue_pixel(input rgb_t p);
        pending_pixels.push_back(p);
        pixels_queued++;
        if (gen_col + 1 >= eff_width())
        begin
            gen_col = 0;
            gen_row = (gen_row + 1 >= eff_height()) ? 0 : gen_row + 1;
        end
        else
            gen_col++;
    endtask

    // Random pixels until the raster returns to the start of a frame.
    task automatic queue_frame_rest();
        do
            queue_pixel(random_pixel());
        while (gen_row != 0 || gen_col != 0);
    endtask

    // Wait until every queued pixel is taken and every result is in, then let the pipe settle.
    task automatic drain();
        while (pixels_taken != pixels_queued || awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = rsh_pkg::REG_IMAGE_WIDTH;
        cfg_data         = '0;
        pix_in.valid     = 1'b0;
        pix_in.in_red    = '0;
        pix_in.in_green  = '0;
        pix_in.in_blue   = '0;
        pix_out.ready    = 1'b0;
        in_taken         = 1'b0;
        pixels_queued    = 0;
        pixels_taken     = 0;
        results_checked  = 0;
        mismatch_count   = 0;
        settings_used    = 0;
        cycle_count      = 0;
        gen_row          = 0;
        gen_col          = 0;
        hold_left        = 0;
        row_pos          = 0;
        col_pos          = 0;
        cfg_width        = rsh_pkg::WIDTH_RESET;
        cfg_height       = rsh_pkg::HEIGHT_RESET;
        foreach (win[k])
            win[k] = '0;
        for (int k = 0; k < MAX_W; k++)
        begin
            line_one[k] = '0;
            line_two[k] = '0;
        end
        set_idle(0, 0);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Smallest frame: one interior pixel copied to all nine positions, clamped high.
        set_frame(3, 3);
        for (int rr = 0; rr < 3; rr++)
        begin
            for (int cc = 0; cc < 3; cc++)
            begin
                if (rr == 1 && cc == 1)
                    queue_pixel(rgb_t'{8'd255, 8'd60, 8'd0});
                else if (rr == 1 || cc == 1)
                    queue_pixel(rgb_t'{8'd0, 8'd40, 8'd0});
                else
                    queue_pixel(rgb_t'{8'd255, 8'd255, 8'd255});
            end
        end
        drain();

        // Checkerboard frame: corners and edges, clamping both ways, mid-range blue.
        set_frame(4, 4);
        for (int rr = 0; rr < 4; rr++)
        begin
            for (int cc = 0; cc < 4; cc++)
            begin
                if ((rr + cc) % 2 == 0)
                    queue_pixel(rgb_t'{8'd255, 8'd0,
                                       rsh_pkg::CH_BITS'(17 * (rr * 4 + cc))});
                else
                    queue_pixel(rgb_t'{8'd0, 8'd255,
                                       rsh_pkg::CH_BITS'(17 * (rr * 4 + cc))});
            end
        end
        drain();

        // Register values below the minimum are clamped up to three.
        set_idle(75, 0);
        set_frame(0, 5);
        queue_frame_rest();
        drain();

        set_idle(0, 75);
        set_frame(4, 3);
        queue_frame_rest();
        drain();

        set_idle(32, 32);
        set_frame(5, 0);
        queue_frame_rest();
        drain();

        // Long receiver hold-off fills the block, then the sender waits for every result.
        set_idle(0, 0);
        set_frame(6, 4);
        hold_left = 300;
        for (int k = 0; k < 20; k++)
            queue_pixel(random_pixel());
        drain();
        queue_frame_rest();
        drain();

        // Tallest frame, cut short by lowering the height while the row count is past it.
        set_idle(32, 32);
        set_frame(3, 65535);
        for (int k = 0; k < 15; k++)
            queue_pixel(random_pixel());
        drain();
        write_register(rsh_pkg::REG_IMAGE_HEIGHT, 3);
        queue_frame_rest();
        drain();

        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        $display("Sent %0d pixels over %0d frame settings and checked %0d output positions.",
                 pixels_queued, settings_used, results_checked);
        $display("Frames from 3x3 to 6x4 and a cut-short tall one, all idling patterns; %0d %s",
                 mismatch_count, "mismatches.");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/rsh_pkg.sv
hw/rtl/rsh_in_if.sv
hw/rtl/rsh_out_if.sv
hw/rtl/rsh_ram.sv
hw/rtl/rsh_core.sv
hw/rtl/rsh_seq.sv
hw/rtl/rgb_sharpen_3x3_cross.sv
hw/rtl/rsh_checker.sv
sim/testbench.sv
